// ===== design/bitmap_select_nth_bit_unit_defines.svh =====
// Assertion macros for the bitmap nth-bit selector.
// Included by the RTL files that carry concurrent checks; expects a clk and rst in scope.
`ifndef BITMAP_SELECT_NTH_BIT_UNIT_DEFINES_SVH
`define BITMAP_SELECT_NTH_BIT_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMSEL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmsel check failed");

// Next-cycle implication, checked outside reset.
`define BMSEL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmsel check failed");

`endif

// ===== design/bmsel_pkg.sv =====
// Shared types and constants for the bitmap nth-bit selector.
// Used by bmsel_byte_scan and bitmap_select_nth_bit_unit; no dependencies.
`default_nettype none

package bmsel_pkg;

  localparam int MAX_BYTES  = 256;
  localparam int POS_W      = $clog2(MAX_BYTES + 1);
  localparam int IDX_W      = 11;
  localparam int MATCH_W    = 12;
  localparam int IDX_FULL_W = POS_W + 3;

  // Ones in each nibble value.
  localparam logic [2:0] NIBBLE_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  typedef struct packed {
    logic [3:0] ones;     // set bits in the byte
    logic [2:0] sel_bit;  // position of the set bit with the requested rank
  } scan_t;

endpackage

`default_nettype wire

// ===== design/bitmap_select_nth_bit_unit.sv =====
// Top level of the bitmap nth-bit selector: input register, run state, result register.
// Depends on bmsel_pkg, bmsel_byte_scan and bitmap_select_nth_bit_unit_defines.svh.
//
// The block takes one bitmap byte per cycle when not stalled, and reports the index of the
// Nth set bit (or Nth clear bit when find_zeros is high on the first byte of a run).
// A byte is held in an input register, then popcounted, compared and searched while
// the run state (match count, byte position, first hit) updates, so the state loop has
// no register inside it. The result for a byte marked last is written to the output
// register as that byte leaves the input register and waits there until taken;
// the input side stalls only when a last byte is pending and the output is still full.
// Bytes at position MAX_BYTES or later do not count but their last mark ends the run.
`default_nettype none
`include "bitmap_select_nth_bit_unit_defines.svh"

module bitmap_select_nth_bit_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic [bmsel_pkg::IDX_W-1:0] target_ordinal,
  input  wire logic                        find_zeros,
  input  wire logic                        last_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             found,
  output logic [bmsel_pkg::IDX_W-1:0]      bit_index
);

  localparam int POS_W   = bmsel_pkg::POS_W;
  localparam int IDX_W   = bmsel_pkg::IDX_W;
  localparam int MATCH_W = bmsel_pkg::MATCH_W;

  // Input register.
  logic             s1_valid;
  logic [7:0]       s1_data;
  logic [IDX_W-1:0] s1_ordinal;
  logic             s1_zeros;
  logic             s1_last;

  // Run state.
  logic [MATCH_W-1:0] match_count;
  logic [POS_W-1:0]   byte_position;
  logic               hit_seen;
  logic [IDX_W-1:0]   hit_index;
  logic [IDX_W-1:0]   held_ordinal;
  logic               held_polarity;

  logic               s1_fire;
  logic               out_free;
  logic               first;
  logic [IDX_W-1:0]   ord;
  logic               pol;
  logic               in_range;
  logic [7:0]         v;
  logic [MATCH_W-1:0] sum;
  logic [MATCH_W-1:0] diff;
  logic               want;
  logic               take;
  bmsel_pkg::scan_t   scan;
  logic [bmsel_pkg::IDX_FULL_W-1:0] idx_full;

  logic [MATCH_W-1:0] match_count_next;
  logic [POS_W-1:0]   byte_position_next;
  logic               hit_seen_next;
  logic [IDX_W-1:0]   hit_index_next;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data    <= data_byte;
      s1_ordinal <= target_ordinal;
      s1_zeros   <= find_zeros;
      s1_last    <= last_byte;
    end
  end

  // Ordinal and mode come straight from the transaction on the first byte of a run.
  assign first    = (byte_position == '0);
  assign ord      = first ? s1_ordinal : held_ordinal;
  assign pol      = first ? s1_zeros : held_polarity;
  assign in_range = (byte_position < POS_W'(bmsel_pkg::MAX_BYTES));
  assign v        = pol ? ~s1_data : s1_data;
  assign sum      = match_count + MATCH_W'(scan.ones);
  assign diff     = MATCH_W'(ord) - match_count;
  assign want     = in_range && !hit_seen;
  assign take     = want && (MATCH_W'(ord) < sum);
  assign idx_full = {byte_position, scan.sel_bit};

  bmsel_byte_scan u_scan (
    .bits (v),
    .rank (diff[2:0]),
    .scan (scan)
  );

  always_comb begin
    match_count_next   = (want && !take) ? sum : match_count;
    byte_position_next = in_range ? byte_position + POS_W'(1) : byte_position;
    hit_seen_next      = hit_seen || take;
    hit_index_next     = take ? IDX_W'(idx_full) : hit_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count   <= '0;
      byte_position <= '0;
      hit_seen      <= 1'b0;
      hit_index     <= '0;
      held_ordinal  <= '0;
      held_polarity <= 1'b0;
    end else if (s1_fire) begin
      if (s1_last) begin
        match_count   <= '0;
        byte_position <= '0;
        hit_seen      <= 1'b0;
        hit_index     <= '0;
        held_ordinal  <= '0;
        held_polarity <= 1'b0;
      end else begin
        match_count   <= match_count_next;
        byte_position <= byte_position_next;
        hit_seen      <= hit_seen_next;
        hit_index     <= hit_index_next;
        held_ordinal  <= ord;
        held_polarity <= pol;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      found     <= hit_seen_next;
      bit_index <= hit_seen_next ? hit_index_next : '0;
    end
  end

  `BMSEL_ASSERT_IMP(a_not_found_zero_index, out_valid && !found, bit_index == '0)
  `BMSEL_ASSERT_NEXT(a_last_clears_run, s1_fire && s1_last,
                     out_valid && byte_position == '0 && !hit_seen)
  `BMSEL_ASSERT_IMP(a_count_below_ordinal, 1'b1, match_count <= MATCH_W'(held_ordinal))
  `BMSEL_ASSERT_IMP(a_position_saturates, 1'b1,
                    byte_position <= POS_W'(bmsel_pkg::MAX_BYTES))

endmodule

`default_nettype wire

// ===== design/bmsel_byte_scan.sv =====
// Per-byte popcount and in-byte rank select for the bitmap nth-bit selector.
// Depends on bmsel_pkg for the nibble table and the scan_t result type.
`default_nettype none

module bmsel_byte_scan (
  input  wire logic [7:0]  bits,
  input  wire logic [2:0]  rank,
  output bmsel_pkg::scan_t scan
);

  logic [3:0] seen;
  logic [2:0] sel;
  logic       done;

  always_comb begin
    seen = 4'd0;
    sel  = 3'd0;
    done = 1'b0;
    // Walk the byte from bit 0 and stop at the set bit whose rank matches.
    for (int j = 0; j < 8; j++) begin
      if (bits[j] && !done) begin
        if (seen == {1'b0, rank}) begin
          sel  = 3'(j);
          done = 1'b1;
        end
        seen = seen + 4'd1;
      end
    end
  end

  always_comb begin
    scan.ones    = {1'b0, bmsel_pkg::NIBBLE_ONES[bits[3:0]]}
                 + {1'b0, bmsel_pkg::NIBBLE_ONES[bits[7:4]]};
    scan.sel_bit = sel;
  end

endmodule

`default_nettype wire
